>>> hw/rtl/i2r_pkg.sv
package i2r_pkg;

  // field widths and defaults
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 8;

  // base limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // fixed characters
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ERR   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new item
    logic step;       // one restoring division step
    logic out_sign;   // load '-' into the output register
    logic rd;         // read the next stored digit
    logic out_digit;  // load the read digit into the output register
    logic out_err;    // load the error beat
  } i2r_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bad_radix;     // incoming radix outside 2..36
    logic neg;           // captured value is negative
    logic bit_last;      // current step finishes a digit
    logic quo_nxt_zero;  // quotient after this step is zero
    logic cnt_zero;      // no digits left in the buffer
    logic out_free;      // output register can take a beat
  } i2r_stat_t;

  // digit value to lower-case ascii glyph
  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 6'd10) begin
      digit_glyph = CHAR_ZERO + dx;
    end else begin
      digit_glyph = CHAR_A + dx - 8'd10;
    end
  endfunction

endpackage

>>> hw/rtl/i2r_ram.sv
module i2r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/i2r_ctrl.sv
module i2r_ctrl
  import i2r_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  i2r_stat_t stat,
  output i2r_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ERR,
    S_SIGN,
    S_READ,
    S_PUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = stat.bad_radix ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.bit_last && stat.quo_nxt_zero) begin
          state_nxt = stat.neg ? S_SIGN : S_READ;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.out_err = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.out_sign = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (stat.out_free) begin
          cmd.out_digit = 1'b1;
          state_nxt     = stat.cnt_zero ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/i2r_dp.sv
module i2r_dp
  import i2r_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [VALUE_WIDTH-1:0] number,
  input  logic                   is_signed,
  input  logic [RADIX_W-1:0]     radix,
  input  i2r_cmd_t               cmd,
  output i2r_stat_t              stat,
  input  logic                   out_tready,
  output logic                   out_valid,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last,
  output logic                   out_bad
);

  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int BW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DIGIT_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     radix_r;
  logic                   neg_r;
  logic [CW-1:0]          cnt_r;
  logic [BW-1:0]          bit_cnt_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic                   out_bad_r;

  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [DIGIT_W:0]       rem_sh;
  logic                   ge;
  logic [DIGIT_W:0]       rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_nxt;
  logic                   bit_last;
  logic [CW-1:0]          cnt_dec;
  logic [DIGIT_W-1:0]     rd_digit;
  logic                   out_free;

  // sign and magnitude of the incoming value
  assign in_neg = is_signed && number[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~number + 1'b1) : number;

  // one restoring division step, quotient bits shift in at the bottom
  assign rem_sh   = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign ge       = (rem_sh >= {1'b0, radix_r});
  assign rem_nxt  = ge ? (rem_sh - {1'b0, radix_r}) : rem_sh;
  assign quo_nxt  = {quo_r[VALUE_WIDTH-2:0], ge};
  assign bit_last = (bit_cnt_r == BW'(VALUE_WIDTH - 1));
  assign cnt_dec  = cnt_r - 1'b1;

  assign out_free = !out_valid_r || out_tready;

  // status back to the controller
  always_comb begin
    stat.bad_radix    = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    stat.neg          = neg_r;
    stat.bit_last     = bit_last;
    stat.quo_nxt_zero = (quo_nxt == '0);
    stat.cnt_zero     = (cnt_r == '0);
    stat.out_free     = out_free;
  end

  // division registers and digit count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r     <= in_mag;
      rem_r     <= '0;
      radix_r   <= radix;
      neg_r     <= in_neg;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
    end else if (cmd.step) begin
      quo_r <= quo_nxt;
      if (bit_last) begin
        rem_r     <= '0;
        bit_cnt_r <= '0;
        cnt_r     <= cnt_r + 1'b1;
      end else begin
        rem_r     <= rem_nxt[DIGIT_W-1:0];
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
    end else if (cmd.rd) begin
      cnt_r <= cnt_dec;
    end
  end

  // digit buffer, least significant digit at address zero
  i2r_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (cmd.step && bit_last),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_nxt[DIGIT_W-1:0]),
    .re    (cmd.rd),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (rd_digit)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_sign || cmd.out_digit || cmd.out_err) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      out_char_r <= CHAR_ERR;
      out_last_r <= 1'b1;
      out_bad_r  <= 1'b1;
    end else if (cmd.out_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
      out_bad_r  <= 1'b0;
    end else if (cmd.out_digit) begin
      out_char_r <= digit_glyph(rd_digit);
      out_last_r <= (cnt_r == '0);
      out_bad_r  <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_bad   = out_bad_r;

endmodule

>>> hw/rtl/integer_to_radix_string.sv
// a bad base loads its one error beat once the output is free; otherwise the
//   one-bit-per-cycle restoring divider takes VALUE_WIDTH steps per digit, then each
//   character takes a digit buffer read and an output load, after a '-' for a negative value
// one item at a time; the next item is taken once the final beat is loaded
// reset: synchronous active-low rst_n returns the controller to idle and empties the output
module integer_to_radix_string
  import i2r_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // number [VALUE_WIDTH-1:0], is_signed, radix [5:0], zero pad to bytes
  input  logic [((VALUE_WIDTH + 1 + RADIX_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // character [7:0]
  output logic [CHAR_W-1:0]    out_tdata,
  output logic                 out_tlast,
  // bad_base
  output logic                 out_tuser
);

  i2r_cmd_t  cmd;
  i2r_stat_t stat;

  // controller
  i2r_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  i2r_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .number     (in_tdata[VALUE_WIDTH-1:0]),
    .is_signed  (in_tdata[VALUE_WIDTH]),
    .radix      (in_tdata[VALUE_WIDTH+RADIX_W:VALUE_WIDTH+1]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_bad    (out_tuser)
  );

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("controller issued more than one command");

  // error beat is a single zero character that ends the conversion
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == CHAR_ERR))
    else $error("error beat malformed");

  // no new item while a conversion is in progress
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after accept");

  // the buffer is only read while digits remain
  a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !stat.cnt_zero)
    else $error("digit read with an empty buffer");

endmodule

>>> test/integer_to_radix_string_tb.sv
`timescale 1ns / 100ps

module integer_to_radix_string_tb;
  import i2r_pkg::*;

  localparam int NUM_W   = VALUE_WIDTH_DEF;
  localparam int TDATA_W = ((NUM_W + 1 + RADIX_W + 7) / 8) * 8;

  // one expected character beat
  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
    logic              bad;
  } text_beat_t;

  // predicts the text of each accepted number and checks the beats against it
  class radix_text_board;
    text_beat_t text_q[$];
    int         errors;
    int         seen;

    function new();
      errors = 0;
      seen   = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // convert one accepted number into its expected beats
    function void note_input(input logic [NUM_W-1:0] number, input logic is_signed,
                             input logic [RADIX_W-1:0] radix);
      logic [NUM_W-1:0]  mag;
      logic [NUM_W-1:0]  rem;
      logic [CHAR_W-1:0] glyph;
      logic [CHAR_W-1:0] digits[$];
      logic              neg;
      text_beat_t        beat;
      // out of range base: single error beat, sign dropped
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
        beat = '{glyph: CHAR_ERR, last: 1'b1, bad: 1'b1};
        text_q.push_back(beat);
        return;
      end
      neg = is_signed && number[NUM_W-1];
      mag = neg ? (~number + 1'b1) : number;
      // digits come out least significant first
      do begin
        rem   = mag % radix;
        glyph = (rem < 10) ? CHAR_ZERO + rem[CHAR_W-1:0]
                           : CHAR_A + rem[CHAR_W-1:0] - 8'd10;
        digits.push_front(glyph);
        mag   = mag / radix;
      end while (mag != 0);
      if (neg) begin
        beat = '{glyph: CHAR_MINUS, last: 1'b0, bad: 1'b0};
        text_q.push_back(beat);
      end
      foreach (digits[i]) begin
        beat = '{glyph: digits[i], last: (i == digits.size() - 1), bad: 1'b0};
        text_q.push_back(beat);
      end
    endfunction

    // compare one received beat with the oldest expectation
    task check_result(input logic [CHAR_W-1:0] glyph, input logic last, input logic bad);
      text_beat_t exp_beat;
      seen++;
      if (text_q.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected (char %h)", seen, glyph));
        return;
      end
      exp_beat = text_q.pop_front();
      if (glyph !== exp_beat.glyph)
        report($sformatf("beat %0d char %h, expected %h", seen, glyph, exp_beat.glyph));
      if (last !== exp_beat.last)
        report($sformatf("beat %0d tlast %b, expected %b", seen, last, exp_beat.last));
      if (bad !== exp_beat.bad)
        report($sformatf("beat %0d bad base %b, expected %b", seen, bad, exp_beat.bad));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [CHAR_W-1:0]  out_tdata;
  logic               out_tlast;
  logic               out_tuser;

  radix_text_board sb = new();

  integer_to_radix_string #(
    .VALUE_WIDTH(NUM_W)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tdata[NUM_W-1:0], in_tdata[NUM_W], in_tdata[NUM_W+1 +: RADIX_W]);
  end

  // output beats get checked
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // offer one number, optional idle cycles first, then hold until taken
  task automatic send_number(input logic [NUM_W-1:0] number, input logic is_signed,
                             input logic [RADIX_W-1:0] radix, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({radix, is_signed, number});
    do @(posedge clk); while (!in_tready);
  endtask

  // random number with a bias toward edge values and short texts
  function automatic logic [NUM_W-1:0] pick_number();
    logic [NUM_W-1:0] n;
    case ($urandom_range(0, 5))
      0: n = $urandom_range(0, 40);
      1: n = {NUM_W{1'b1}} - $urandom_range(0, 100);
      2: begin
        case ($urandom_range(0, 4))
          0: n = '0;
          1: n = 1;
          2: n = {1'b0, {(NUM_W-1){1'b1}}};
          3: n = {1'b1, {(NUM_W-1){1'b0}}};
          default: n = '1;
        endcase
      end
      3: n = $urandom >> $urandom_range(0, NUM_W - 1);
      default: n = $urandom;
    endcase
    return n;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                  : RADIX_W'($urandom_range(37, 63));
    return RADIX_W'($urandom_range(2, 36));
  endfunction

  // receiver: random stalls, a run without stalls, one long hold-off
  initial begin : sink
    int gap;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && sb.seen >= 60) begin
        held = 1'b1;
        gap  = 600;
      end else if (sb.seen >= 150 && sb.seen < 300) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // reset, directed numbers, random numbers, drain
  initial begin : stim
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // zero, extremes, most negative, every base edge
    send_number(32'd0,          1'b0, 6'd10, 1'b0);
    send_number(32'd0,          1'b1, 6'd2,  1'b0);
    send_number(32'hffff_ffff,  1'b0, 6'd2,  1'b0);
    send_number(32'hffff_ffff,  1'b1, 6'd10, 1'b0);
    send_number(32'h8000_0000,  1'b1, 6'd10, 1'b0);
    send_number(32'h8000_0000,  1'b1, 6'd2,  1'b0);
    send_number(32'h8000_0000,  1'b0, 6'd16, 1'b0);
    send_number(32'h7fff_ffff,  1'b1, 6'd36, 1'b0);
    send_number(32'hffff_ffff,  1'b0, 6'd36, 1'b0);
    send_number(32'hffff_ffff,  1'b0, 6'd10, 1'b0);
    send_number(32'd35,         1'b0, 6'd36, 1'b0);
    send_number(32'd36,         1'b1, 6'd36, 1'b0);
    send_number(32'hdead_beef,  1'b0, 6'd16, 1'b0);
    send_number(32'd12345,      1'b1, 6'd3,  1'b0);
    send_number(32'hffff_ff85,  1'b1, 6'd7,  1'b0);
    // bad base, some with a negative value: no sign expected
    send_number(32'hffff_ffff,  1'b1, 6'd0,  1'b0);
    send_number(32'h8000_0000,  1'b1, 6'd1,  1'b0);
    send_number(32'd100,        1'b0, 6'd37, 1'b0);
    send_number(32'hffff_fff0,  1'b1, 6'd63, 1'b0);

    // random part, with a run of back-to-back offers
    for (int i = 0; i < 111; i++)
      send_number(pick_number(), 1'($urandom_range(0, 1)), pick_radix(), i >= 50 && i < 75);
    in_tvalid <= 1'b0;

    // drain and watch for stray beats
    @(posedge clk);
    while (sb.text_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/i2r_pkg.sv
hw/rtl/i2r_ram.sv
hw/rtl/i2r_ctrl.sv
hw/rtl/i2r_dp.sv
hw/rtl/integer_to_radix_string.sv
test/integer_to_radix_string_tb.sv
